FILE: hw/rtl/pet_pkg.sv
package pet_pkg;

  localparam int unsigned NumElementsDef = 16;
  localparam int unsigned MaxRowsDef     = 8;

  localparam int unsigned EstW  = 4;
  localparam int unsigned ElemW = 4;
  localparam int unsigned FpW   = 32;

  // FPU operation codes
  localparam logic [1:0] FOP_ADD = 2'd0;
  localparam logic [1:0] FOP_SUB = 2'd1;
  localparam logic [1:0] FOP_MUL = 2'd2;
  localparam logic [1:0] FOP_RCP = 2'd3;

  // per-row arithmetic steps, issued in this order
  localparam logic [2:0] STEP_SUB  = 3'd0;
  localparam logic [2:0] STEP_RCP  = 3'd1;
  localparam logic [2:0] STEP_F1   = 3'd2;
  localparam logic [2:0] STEP_F2   = 3'd3;
  localparam logic [2:0] STEP_DIFF = 3'd4;
  localparam logic [2:0] STEP_DY   = 3'd5;
  localparam logic [2:0] STEP_C    = 3'd6;
  localparam logic [2:0] STEP_YZ   = 3'd7;

  localparam logic [31:0] FpQuietBit = 32'h0040_0000;
  localparam logic [31:0] FpDefNan   = 32'hFFC0_0000;

  typedef struct packed {
    logic       load;
    logic       fpu_start;
    logic       fpu_capture;
    logic [2:0] step;
    logic       q_capture;
    logic       ram_rd;
    logic       ram_wr;
    logic       wr_last;
    logic       row_inc;
    logic       out_load;
  } pet_cmd_t;

  typedef struct packed {
    logic fpu_done;
    logic est_one;
    logic last_row;
  } pet_status_t;

endpackage

FILE: hw/rtl/pet_ram.sv
module pet_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/pet_fpu.sv
module pet_fpu import pet_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [1:0]  op_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] res_o
);

  localparam logic [3:0] F_IDLE  = 4'd0;
  localparam logic [3:0] F_ALIGN = 4'd1;
  localparam logic [3:0] F_ADD   = 4'd2;
  localparam logic [3:0] F_MUL   = 4'd3;
  localparam logic [3:0] F_RNRM  = 4'd4;
  localparam logic [3:0] F_DIV   = 4'd5;
  localparam logic [3:0] F_LZ    = 4'd6;
  localparam logic [3:0] F_SHL   = 4'd7;
  localparam logic [3:0] F_SHR   = 4'd8;
  localparam logic [3:0] F_RND   = 4'd9;
  localparam logic [3:0] F_DONE  = 4'd10;

  function automatic logic [5:0] lzc50(input logic [49:0] v);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (v[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

  logic [3:0]         fs_q, fs_d;
  logic [31:0]        opa_q, opa_d, opb_q, opb_d, res_q, res_d;
  logic               s_q, s_d, sub_q, sub_d;
  logic signed [11:0] ex_q, ex_d;
  logic [49:0]        m_q, m_d, sm_q, sm_d;
  logic [23:0]        den_q, den_d, mant_q, mant_d;
  logic [25:0]        rem_q, rem_d;
  logic [26:0]        quo_q, quo_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [5:0]         lz_q, lz_d;
  logic               g_q, g_d, stk_q, stk_d;
  logic [9:0]         base_q, base_d;

  // operand fields
  logic [23:0] sig_a, sig_b;
  logic [7:0]  exp_a, exp_b;
  always_comb begin
    sig_a = {opa_q[30:23] != 8'd0, opa_q[22:0]};
    sig_b = {opb_q[30:23] != 8'd0, opb_q[22:0]};
    exp_a = (opa_q[30:23] == 8'd0) ? 8'd1 : opa_q[30:23];
    exp_b = (opb_q[30:23] == 8'd0) ? 8'd1 : opb_q[30:23];
  end

  // special operands, checked on the incoming word
  logic        sbe, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, spec;
  logic [31:0] spec_val;
  always_comb begin
    sbe    = b_i[31] ^ (op_i == FOP_SUB);
    a_nan  = (a_i[30:23] == 8'hFF) && (a_i[22:0] != 23'd0);
    b_nan  = (b_i[30:23] == 8'hFF) && (b_i[22:0] != 23'd0);
    a_inf  = (a_i[30:23] == 8'hFF) && (a_i[22:0] == 23'd0);
    b_inf  = (b_i[30:23] == 8'hFF) && (b_i[22:0] == 23'd0);
    a_zero = a_i[30:0] == 31'd0;
    b_zero = b_i[30:0] == 31'd0;
    spec     = 1'b1;
    spec_val = 32'd0;
    case (op_i)
      FOP_ADD, FOP_SUB: begin
        if (a_nan) spec_val = a_i | FpQuietBit;
        else if (b_nan) spec_val = b_i | FpQuietBit;
        else if (a_inf && b_inf && (a_i[31] != sbe)) spec_val = FpDefNan;
        else if (a_inf) spec_val = a_i;
        else if (b_inf) spec_val = {sbe, b_i[30:0]};
        else if (a_zero && b_zero) spec_val = {a_i[31] & sbe, 31'd0};
        else spec = 1'b0;
      end
      FOP_MUL: begin
        if (a_nan) spec_val = a_i | FpQuietBit;
        else if (b_nan) spec_val = b_i | FpQuietBit;
        else if ((a_inf && b_zero) || (a_zero && b_inf)) spec_val = FpDefNan;
        else if (a_inf || b_inf) spec_val = {a_i[31] ^ b_i[31], 31'h7F80_0000};
        else if (a_zero || b_zero) spec_val = {a_i[31] ^ b_i[31], 31'd0};
        else spec = 1'b0;
      end
      default: begin
        if (a_nan) spec_val = a_i | FpQuietBit;
        else if (a_zero) spec_val = {a_i[31], 31'h7F80_0000};
        else if (a_inf) spec_val = {a_i[31], 31'd0};
        else spec = 1'b0;
      end
    endcase
  end

  logic        a_ge, div_ge;
  logic [31:0] big, sml;
  logic [23:0] sig_s, sig_bg;
  logic [7:0]  exp_bg, exp_sm, dexp;
  logic [5:0]  dcl;
  logic [99:0] wide;
  logic [47:0] prod;
  logic [5:0]  lzd;
  logic [25:0] r1;
  logic [11:0] rs;
  logic [4:0]  rcl;
  logic [75:0] shr;
  logic        inc;
  logic [32:0] pk;

  always_comb begin
    fs_d = fs_q; opa_d = opa_q; opb_d = opb_q; res_d = res_q;
    s_d = s_q; sub_d = sub_q; ex_d = ex_q; m_d = m_q; sm_d = sm_q;
    den_d = den_q; mant_d = mant_q; rem_d = rem_q; quo_d = quo_q;
    cnt_d = cnt_q; lz_d = lz_q; g_d = g_q; stk_d = stk_q; base_d = base_q;
    done_o = 1'b0;

    a_ge   = opa_q[30:0] >= opb_q[30:0];
    big    = a_ge ? opa_q : opb_q;
    sml    = a_ge ? opb_q : opa_q;
    sig_bg = a_ge ? sig_a : sig_b;
    sig_s  = a_ge ? sig_b : sig_a;
    exp_bg = a_ge ? exp_a : exp_b;
    exp_sm = a_ge ? exp_b : exp_a;
    dexp   = exp_bg - exp_sm;
    dcl    = (dexp > 8'd50) ? 6'd50 : dexp[5:0];
    wide   = {1'b0, sig_s, 75'd0} >> dcl;
    prod   = sig_a * sig_b;
    lzd    = lzc50({sig_a, 26'd0});
    div_ge = rem_q >= {2'b00, den_q};
    r1     = div_ge ? rem_q - {2'b00, den_q} : rem_q;
    rs     = 12'(12'sd1 - ex_q);
    rcl    = (rs > 12'd26) ? 5'd26 : rs[4:0];
    shr    = {m_q, 26'd0} >> rcl;
    inc    = g_q & (stk_q | mant_q[0]);
    pk     = {base_q, 23'd0} + {9'd0, mant_q} + {32'd0, inc};

    unique case (fs_q)
      F_IDLE: begin
        if (start_i) begin
          opa_d = a_i;
          opb_d = {sbe, b_i[30:0]};
          if (spec) begin
            res_d = spec_val;
            fs_d  = F_DONE;
          end else if (op_i == FOP_MUL) begin
            fs_d = F_MUL;
          end else if (op_i == FOP_RCP) begin
            fs_d = F_RNRM;
          end else begin
            fs_d = F_ALIGN;
          end
        end
      end
      F_ALIGN: begin
        s_d   = big[31];
        sub_d = opa_q[31] ^ opb_q[31];
        ex_d  = signed'({4'd0, exp_bg});
        m_d   = {1'b0, sig_bg, 25'd0};
        sm_d  = wide[99:50] | {49'd0, |wide[49:0]};
        fs_d  = F_ADD;
      end
      F_ADD: begin
        m_d  = sub_q ? m_q - sm_q : m_q + sm_q;
        fs_d = F_LZ;
      end
      F_MUL: begin
        s_d  = opa_q[31] ^ opb_q[31];
        ex_d = signed'({4'd0, exp_a}) + signed'({4'd0, exp_b}) - 12'sd127;
        m_d  = {prod, 2'b00};
        fs_d = F_LZ;
      end
      F_RNRM: begin
        s_d   = opa_q[31];
        den_d = sig_a << lzd;
        ex_d  = 12'sd254 + signed'({6'd0, lzd}) - signed'({4'd0, exp_a});
        rem_d = 26'h080_0000;
        quo_d = 27'd0;
        cnt_d = 5'd0;
        fs_d  = F_DIV;
      end
      F_DIV: begin
        rem_d = {r1[24:0], 1'b0};
        quo_d = {quo_q[25:0], div_ge};
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'd26) begin
          m_d  = {1'b0, quo_q[25:0], div_ge, 21'd0, r1 != 26'd0};
          fs_d = F_LZ;
        end
      end
      F_LZ: begin
        if (m_q == 50'd0) begin
          res_d = 32'd0;   // exact cancellation gives +0
          fs_d  = F_DONE;
        end else begin
          lz_d = lzc50(m_q);
          fs_d = F_SHL;
        end
      end
      F_SHL: begin
        m_d  = m_q << lz_q;
        ex_d = ex_q + 12'sd1 - signed'({6'd0, lz_q});
        fs_d = F_SHR;
      end
      F_SHR: begin
        if (ex_q > 12'sd0) begin
          mant_d = m_q[49:26];
          g_d    = m_q[25];
          stk_d  = |m_q[24:0];
          base_d = 10'(ex_q - 12'sd1);
        end else begin
          // subnormal result
          mant_d = shr[75:52];
          g_d    = shr[51];
          stk_d  = |shr[50:0];
          base_d = 10'd0;
        end
        fs_d = F_RND;
      end
      F_RND: begin
        if (pk >= 33'h0_7F80_0000) res_d = {s_q, 31'h7F80_0000};
        else res_d = {s_q, pk[30:0]};
        fs_d = F_DONE;
      end
      F_DONE: begin
        done_o = 1'b1;
        fs_d   = F_IDLE;
      end
      default: fs_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q <= F_IDLE;
    end else begin
      fs_q <= fs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    opa_q <= opa_d; opb_q <= opb_d; res_q <= res_d;
    s_q <= s_d; sub_q <= sub_d; ex_q <= ex_d; m_q <= m_d; sm_q <= sm_d;
    den_q <= den_d; mant_q <= mant_d; rem_q <= rem_d; quo_q <= quo_d;
    cnt_q <= cnt_d; lz_q <= lz_d; g_q <= g_d; stk_q <= stk_d; base_q <= base_d;
  end

  assign res_o = res_q;

endmodule

FILE: hw/rtl/pet_ctrl.sv
module pet_ctrl import pet_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pet_cmd_t    cmd_o,
  input  pet_status_t status_i
);

  localparam logic [2:0] C_IDLE  = 3'd0;
  localparam logic [2:0] C_START = 3'd1;
  localparam logic [2:0] C_RD    = 3'd2;
  localparam logic [2:0] C_OP    = 3'd3;
  localparam logic [2:0] C_NEXT  = 3'd4;
  localparam logic [2:0] C_WRL   = 3'd5;
  localparam logic [2:0] C_DONE  = 3'd6;

  logic [2:0] st_q, st_d, step_q, step_d;
  logic       busy_q, busy_d, out_valid_q, out_valid_d;

  always_comb begin
    st_d   = st_q;
    step_d = step_q;
    busy_d = busy_q;
    cmd_o  = '0;
    cmd_o.step = step_q;
    unique case (st_q)
      C_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          st_d = C_START;
        end
      end
      C_START: st_d = status_i.est_one ? C_WRL : C_RD;
      C_RD: begin
        cmd_o.ram_rd = 1'b1;
        step_d = STEP_SUB;
        busy_d = 1'b0;
        st_d   = C_OP;
      end
      C_OP: begin
        if (!busy_q) begin
          cmd_o.fpu_start = 1'b1;
          busy_d = 1'b1;
          if (step_q == STEP_SUB) begin
            // old diagonal word is taken, then overwritten with dy
            cmd_o.q_capture = 1'b1;
            cmd_o.ram_wr    = 1'b1;
          end
        end else if (status_i.fpu_done) begin
          cmd_o.fpu_capture = 1'b1;
          busy_d = 1'b0;
          if (step_q == STEP_YZ) st_d = C_NEXT;
          else step_d = step_q + 3'd1;
        end
      end
      C_NEXT: begin
        if (status_i.last_row) begin
          st_d = C_WRL;
        end else begin
          cmd_o.row_inc = 1'b1;
          st_d = C_RD;
        end
      end
      C_WRL: begin
        cmd_o.ram_wr  = 1'b1;
        cmd_o.wr_last = 1'b1;
        st_d = C_DONE;
      end
      C_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          st_d = C_IDLE;
        end
      end
      default: st_d = C_IDLE;
    endcase

    if (cmd_o.out_load) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= C_IDLE;
      step_q      <= STEP_SUB;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      step_q      <= step_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = st_q == C_IDLE;
  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/pet_datapath.sv
module pet_datapath import pet_pkg::*; #(
  parameter int unsigned NumElements = NumElementsDef,
  parameter int unsigned MaxRows     = MaxRowsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  pet_cmd_t          cmd_i,
  output pet_status_t       status_o,
  input  logic [EstW-1:0]   est_number_i,
  input  logic [FpW-1:0]    abscissa_i,
  input  logic [ElemW-1:0]  element_index_i,
  input  logic [FpW-1:0]    estimate_value_i,
  output logic [ElemW-1:0]  element_out_o,
  output logic [FpW-1:0]    extrapolated_o,
  output logic [FpW-1:0]    error_estimate_o
);

  localparam int unsigned EW    = (NumElements > 1) ? $clog2(NumElements) : 1;
  localparam int unsigned RW    = $clog2(MaxRows);
  localparam int unsigned Depth = NumElements * MaxRows;
  localparam int unsigned AW    = $clog2(Depth);

  // element index folded into the element range
  logic [EW-1:0] elem_tbl [16];
  for (genvar k = 0; k < 16; k++) begin : g_elem
    localparam int unsigned ElemMod = k % NumElements;
    assign elem_tbl[k] = EW'(ElemMod);
  end

  logic [FpW-1:0]   hist_q [MaxRows];
  logic [FpW-1:0]   xest_q, xold, inv_q, f1_q, f2_q, q_q, c_q, dy_q, yz_q, diff_q;
  logic [RW-1:0]    estm1_q, estm1_d, rm1_q, hidx;
  logic [AW-1:0]    base_q, raddr, waddr;
  logic [ElemW-1:0] elem_in_q, elem_out_q;
  logic [FpW-1:0]   extr_q, err_q, ram_rdata, fpu_res;
  logic [FpW-1:0]   fa, fb;
  logic [1:0]       fop;
  logic             fpu_done;

  always_comb begin
    if (est_number_i == '0) estm1_d = '0;
    else if ({1'b0, est_number_i} > 5'(MaxRows)) estm1_d = RW'(MaxRows - 1);
    else estm1_d = RW'(est_number_i - 4'd1);
  end

  assign hidx = estm1_q - rm1_q - RW'(1);
  assign xold = hist_q[hidx];
  assign raddr = base_q + AW'(rm1_q);
  assign waddr = cmd_i.wr_last ? base_q + AW'(estm1_q) : raddr;

  always_comb begin
    fa  = xold;
    fb  = xest_q;
    fop = FOP_MUL;
    unique case (cmd_i.step)
      STEP_SUB:  begin fa = xold;   fb = xest_q; fop = FOP_SUB; end
      STEP_RCP:  begin fa = inv_q;  fb = inv_q;  fop = FOP_RCP; end
      STEP_F1:   begin fa = xest_q; fb = inv_q;  fop = FOP_MUL; end
      STEP_F2:   begin fa = xold;   fb = inv_q;  fop = FOP_MUL; end
      STEP_DIFF: begin fa = c_q;    fb = q_q;    fop = FOP_SUB; end
      STEP_DY:   begin fa = f1_q;   fb = diff_q; fop = FOP_MUL; end
      STEP_C:    begin fa = f2_q;   fb = diff_q; fop = FOP_MUL; end
      STEP_YZ:   begin fa = yz_q;   fb = dy_q;   fop = FOP_ADD; end
      default:   ;
    endcase
  end

  pet_fpu u_fpu (
    .clk_i,
    .rst_ni,
    .start_i (cmd_i.fpu_start),
    .op_i    (fop),
    .a_i     (fa),
    .b_i     (fb),
    .done_o  (fpu_done),
    .res_o   (fpu_res)
  );

  pet_ram #(
    .Width (FpW),
    .Depth (Depth)
  ) u_diag_ram (
    .clk_i,
    .we_i    (cmd_i.ram_wr),
    .waddr_i (waddr),
    .wdata_i (dy_q),
    .re_i    (cmd_i.ram_rd),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      hist_q[estm1_d] <= abscissa_i;
      xest_q    <= abscissa_i;
      yz_q      <= estimate_value_i;
      dy_q      <= estimate_value_i;
      c_q       <= estimate_value_i;
      elem_in_q <= element_index_i;
      estm1_q   <= estm1_d;
      base_q    <= AW'(elem_tbl[element_index_i]) * AW'(MaxRows);
      rm1_q     <= '0;
    end
    if (cmd_i.row_inc) rm1_q <= rm1_q + RW'(1);
    if (cmd_i.q_capture) q_q <= ram_rdata;
    if (cmd_i.fpu_capture) begin
      case (cmd_i.step)
        STEP_SUB, STEP_RCP: inv_q <= fpu_res;
        STEP_F1:   f1_q   <= fpu_res;
        STEP_F2:   f2_q   <= fpu_res;
        STEP_DIFF: diff_q <= fpu_res;
        STEP_DY:   dy_q   <= fpu_res;
        STEP_C:    c_q    <= fpu_res;
        default:   yz_q   <= fpu_res;
      endcase
    end
    if (cmd_i.out_load) begin
      elem_out_q <= elem_in_q;
      extr_q     <= yz_q;
      err_q      <= dy_q;
    end
  end

  assign status_o.fpu_done = fpu_done;
  assign status_o.est_one  = estm1_q == '0;
  assign status_o.last_row = rm1_q == estm1_q - RW'(1);

  assign element_out_o    = elem_out_q;
  assign extrapolated_o   = extr_q;
  assign error_estimate_o = err_q;

endmodule

FILE: hw/rtl/polynomial_extrapolation_tableau_core.sv
// Polynomial extrapolation to zero over a Neville tableau, IEEE single.
// Input channel (in_valid_i/in_ready_o) takes one word per element of an
// estimate: estimate number, abscissa, element index and value. Estimates
// of an element must come in order 1, 2, ... up to MaxRows.
// Output channel (out_valid_o/out_ready_i) returns one word per input word:
// the echoed element index, the extrapolated value and the error term.
// One item is processed at a time. Estimate k walks k-1 tableau rows; each
// row runs eight float operations on one shared FPU, whose time goes mostly
// to the bit-serial reciprocal, plus row control. NaN, infinity and zero
// operands finish their operation sooner. The next word is taken the cycle
// after the result is loaded.
// The result sits in an output register, so the next word is accepted
// while a result still waits; a stalled receiver holds the block only once
// a second result is finished.
// Reset clears the control state; the abscissa history and the diagonal
// memory hold nothing valid until the matching estimates are written.
module polynomial_extrapolation_tableau_core import pet_pkg::*; #(
  parameter int unsigned NumElements = NumElementsDef,
  parameter int unsigned MaxRows     = MaxRowsDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [EstW-1:0]  est_number_i,
  input  logic [FpW-1:0]   abscissa_i,
  input  logic [ElemW-1:0] element_index_i,
  input  logic [FpW-1:0]   estimate_value_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ElemW-1:0] element_out_o,
  output logic [FpW-1:0]   extrapolated_o,
  output logic [FpW-1:0]   error_estimate_o
);

  pet_cmd_t    cmd;
  pet_status_t status;

  pet_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .out_valid_o,
    .out_ready_i,
    .cmd_o    (cmd),
    .status_i (status)
  );

  pet_datapath #(
    .NumElements (NumElements),
    .MaxRows     (MaxRows)
  ) u_datapath (
    .clk_i,
    .rst_ni,
    .cmd_i    (cmd),
    .status_o (status),
    .est_number_i,
    .abscissa_i,
    .element_index_i,
    .estimate_value_i,
    .element_out_o,
    .extrapolated_o,
    .error_estimate_o
  );

endmodule
